[rtl/smx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_pkg
// Shared constants and the exp step table for the softmax vector unit.
// ----------------------------------------------------------------------------
package smx_pkg;

   localparam int MAX_LEN_DEF = 64;
   localparam int LOGIT_W     = 16;
   localparam int PROB_W      = 16;
   localparam int E_W         = 17;
   localparam int SUM_W       = 23;
   localparam int EXP_BITS    = 13;
   localparam int EXP_IDX_W   = 4;

   localparam logic [31:0] EXP_STEP = 32'd4278222805;

   function automatic logic [31:0] exp_base(input int j);
      logic [63:0] b;
      b = {32'd0, EXP_STEP};
      for (int k = 0; k < j; k++) begin
         b = (b * b + 64'd2147483648) >> 32;
      end
      return b[31:0];
   endfunction

   localparam logic [31:0] EXP_BASE [EXP_BITS] = '{
      exp_base(0), exp_base(1), exp_base(2), exp_base(3), exp_base(4),
      exp_base(5), exp_base(6), exp_base(7), exp_base(8), exp_base(9),
      exp_base(10), exp_base(11), exp_base(12)
   };

endpackage

[rtl/smx_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_req_if
// Logit item channel: valid/ready with logit and last flag.
// ----------------------------------------------------------------------------
interface smx_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [smx_pkg::LOGIT_W-1:0] logit;
   logic                              last;

   modport source (output valid, output logit, output last, input ready);
   modport sink   (input valid, input logit, input last, output ready);
endinterface

[rtl/smx_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_rsp_if
// Probability item channel: valid/ready with probability and final flag.
// ----------------------------------------------------------------------------
interface smx_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [smx_pkg::PROB_W-1:0] probability;
   logic                       final_res;

   modport source (output valid, output probability, output final_res, input ready);
   modport sink   (input valid, input probability, input final_res, output ready);
endinterface

[rtl/softmax_vector_unit.sv]
`timescale 1ns / 1ps
// Loading: one logit item per cycle, ready held high while a vector is taken in.
// After the last item: per stored element, a sum pass of store read, exp start and
// exp wait, then an output pass of read, exp, divide and the output handshake; the
// single shared exp unit (13 multiply steps) serves both passes, the 17-step divider the output pass.
// Reset: synchronous, clears count, running maximum, sum and sequencer; the
// logit store keeps its contents.
// ----------------------------------------------------------------------------
// softmax_vector_unit
// Stable softmax over a vector of Q8.8 logits, sequenced over a shared exp unit.
// ----------------------------------------------------------------------------
module softmax_vector_unit #(
   parameter int MAX_LEN = smx_pkg::MAX_LEN_DEF
) (
   input  logic      clock,
   input  logic      reset,
   smx_req_if.sink   req_if,
   smx_rsp_if.source rsp_if
);

   localparam int CNT_W  = $clog2(MAX_LEN + 1);
   localparam int ADDR_W = $clog2(MAX_LEN);

   localparam logic [3:0] ST_LOAD   = 4'd0;
   localparam logic [3:0] ST_S_RD   = 4'd1;
   localparam logic [3:0] ST_S_GO   = 4'd2;
   localparam logic [3:0] ST_S_EXP  = 4'd3;
   localparam logic [3:0] ST_P_RD   = 4'd4;
   localparam logic [3:0] ST_P_GO   = 4'd5;
   localparam logic [3:0] ST_P_EXP  = 4'd6;
   localparam logic [3:0] ST_P_DIV  = 4'd7;
   localparam logic [3:0] ST_OUT    = 4'd8;

   logic [3:0]                         state_ff, state_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic [CNT_W-1:0]                   idx_ff, idx_in;
   logic signed [smx_pkg::LOGIT_W-1:0] max_ff, max_in;
   logic [smx_pkg::SUM_W-1:0]          sum_ff, sum_in;
   logic [smx_pkg::PROB_W-1:0]         prob_ff, prob_in;
   logic                               fin_ff, fin_in;

   logic                               accept, store, is_end, div_start;
   logic [smx_pkg::LOGIT_W-1:0]        rd_data;
   logic signed [smx_pkg::LOGIT_W:0]   diff;
   logic                               exp_start, exp_done, div_done;
   logic [smx_pkg::E_W-1:0]            exp_e;
   logic [smx_pkg::PROB_W-1:0]         div_q;

   assign req_if.ready = (state_ff == ST_LOAD);
   assign accept       = req_if.valid && req_if.ready;
   assign store        = accept && (count_ff < CNT_W'(MAX_LEN));
   assign is_end       = (idx_ff == count_ff - 1'b1);

   smx_ram #(.WIDTH(smx_pkg::LOGIT_W), .DEPTH(MAX_LEN)) u_store (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_if.logit),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign diff      = {max_ff[smx_pkg::LOGIT_W-1], max_ff}
                    - {rd_data[smx_pkg::LOGIT_W-1], rd_data};
   assign exp_start = (state_ff == ST_S_GO) || (state_ff == ST_P_GO);

   smx_exp u_exp (
      .clock (clock),
      .reset (reset),
      .start (exp_start),
      .n     (diff[smx_pkg::EXP_BITS-1:0]),
      .big   (diff[smx_pkg::LOGIT_W:smx_pkg::EXP_BITS] != '0),
      .done  (exp_done),
      .e     (exp_e)
   );

   assign div_start = (state_ff == ST_P_EXP) && exp_done;

   smx_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num_e (exp_e),
      .den   (sum_ff),
      .done  (div_done),
      .quo   (div_q)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      max_in   = max_ff;
      sum_in   = sum_ff;
      prob_in  = prob_ff;
      fin_in   = fin_ff;
      case (state_ff)
         ST_LOAD: begin
            if (store) begin
               count_in = count_ff + 1'b1;
               if (req_if.logit > max_ff) begin
                  max_in = req_if.logit;
               end
            end
            if (accept && req_if.last) begin
               idx_in   = '0;
               sum_in   = '0;
               state_in = ST_S_RD;
            end
         end
         ST_S_RD:  state_in = ST_S_GO;
         ST_S_GO:  state_in = ST_S_EXP;
         ST_S_EXP: begin
            if (exp_done) begin
               sum_in = sum_ff + smx_pkg::SUM_W'(exp_e);
               if (is_end) begin
                  idx_in   = '0;
                  state_in = ST_P_RD;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_S_RD;
               end
            end
         end
         ST_P_RD:  state_in = ST_P_GO;
         ST_P_GO:  state_in = ST_P_EXP;
         ST_P_EXP: begin
            if (exp_done) begin
               state_in = ST_P_DIV;
            end
         end
         ST_P_DIV: begin
            if (div_done) begin
               prob_in  = div_q;
               fin_in   = is_end;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_if.ready) begin
               if (fin_ff) begin
                  count_in = '0;
                  max_in   = {1'b1, {(smx_pkg::LOGIT_W-1){1'b0}}};
                  sum_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_P_RD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         idx_ff   <= '0;
         max_ff   <= {1'b1, {(smx_pkg::LOGIT_W-1){1'b0}}};
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         max_ff   <= max_in;
         sum_ff   <= sum_in;
      end
      prob_ff <= prob_in;
      fin_ff  <= fin_in;
   end

   assign rsp_if.valid       = (state_ff == ST_OUT);
   assign rsp_if.probability = prob_ff;
   assign rsp_if.final_res   = fin_ff;

endmodule

[rtl/smx_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module smx_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/smx_exp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_exp
// Iterative exp(-n/256): one table step per bit of n, multiplying in the entry for each set bit, Q1.16 result.
// ----------------------------------------------------------------------------
module smx_exp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [smx_pkg::EXP_BITS-1:0]     n,
   input  logic                             big,
   output logic                             done,
   output logic [smx_pkg::E_W-1:0]          e
);

   logic                             run_ff, run_in;
   logic [smx_pkg::EXP_IDX_W-1:0]    j_ff, j_in;
   logic [31:0]                      r_ff, r_in;
   logic                             one_ff, one_in;
   logic [smx_pkg::EXP_BITS-1:0]     n_ff, n_in;
   logic                             zero_ff, zero_in;
   logic                             done_ff, done_in;
   logic [smx_pkg::E_W-1:0]          e_ff, e_in;
   logic [31:0]                      base;
   logic [63:0]                      prod;
   logic [32:0]                      rnd;

   assign base = smx_pkg::EXP_BASE[j_ff];
   assign prod = {32'd0, r_ff} * {32'd0, base} + 64'h0000_0000_8000_0000;

   always_comb begin
      run_in  = run_ff;
      j_in    = j_ff;
      r_in    = r_ff;
      one_in  = one_ff;
      n_in    = n_ff;
      zero_in = zero_ff;
      done_in = 1'b0;
      e_in    = e_ff;
      rnd     = '0;
      if (start) begin
         run_in  = 1'b1;
         j_in    = '0;
         r_in    = '0;
         one_in  = 1'b1;
         n_in    = n;
         zero_in = big;
      end else if (run_ff) begin
         if (n_ff[j_ff]) begin
            if (one_ff) begin
               r_in   = base;
               one_in = 1'b0;
            end else begin
               r_in = prod[63:32];
            end
         end
         j_in = j_ff + 1'b1;
         if (j_ff == smx_pkg::EXP_IDX_W'(smx_pkg::EXP_BITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            rnd     = {1'b0, r_in} + 33'd32768;
            if (zero_ff) begin
               e_in = '0;
            end else if (one_in) begin
               e_in = smx_pkg::E_W'(65536);
            end else begin
               e_in = rnd[32:16];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      j_ff    <= j_in;
      r_ff    <= r_in;
      one_ff  <= one_in;
      n_ff    <= n_in;
      zero_ff <= zero_in;
      e_ff    <= e_in;
   end

   assign done = done_ff;
   assign e    = e_ff;

endmodule

[rtl/smx_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_div
// Restoring divider: rounded (e * 65536) / sum, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smx_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [smx_pkg::E_W-1:0]      num_e,
   input  logic [smx_pkg::SUM_W-1:0]    den,
   output logic                         done,
   output logic [smx_pkg::PROB_W-1:0]   quo
);

   localparam int REM_W = 33;
   localparam int D_W   = smx_pkg::SUM_W + 16;

   logic                       run_ff, run_in;
   logic [4:0]                 k_ff, k_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [D_W-1:0]             d_ff, d_in;
   logic [16:0]                q_ff, q_in;
   logic                       zero_ff, zero_in;
   logic                       done_ff, done_in;
   logic [smx_pkg::PROB_W-1:0] quo_ff, quo_in;
   logic [D_W-1:0]             rem_ext, diff;
   logic                       ge;

   assign rem_ext = {{(D_W-REM_W){1'b0}}, rem_ff};
   assign ge      = rem_ext >= d_ff;
   assign diff    = rem_ext - d_ff;

   always_comb begin
      run_in  = run_ff;
      k_in    = k_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      zero_in = zero_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      if (start) begin
         run_in  = 1'b1;
         k_in    = '0;
         rem_in  = {num_e, 16'd0} + REM_W'(den >> 1);
         d_in    = {den, 16'd0};
         q_in    = '0;
         zero_in = (den == '0);
      end else if (run_ff) begin
         if (ge) begin
            rem_in = diff[REM_W-1:0];
         end
         q_in = {q_ff[15:0], ge};
         d_in = d_ff >> 1;
         k_in = k_ff + 1'b1;
         if (k_ff == 5'd16) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            if (zero_ff) begin
               quo_in = '0;
            end else if (q_in[16]) begin
               quo_in = '1;
            end else begin
               quo_in = q_in[15:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      k_ff    <= k_in;
      rem_ff  <= rem_in;
      d_ff    <= d_in;
      q_ff    <= q_in;
      zero_ff <= zero_in;
      quo_ff  <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

[tb/sv/smx_scoreboard.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_scoreboard
// Watches the logit and probability channels of the softmax vector unit,
// rebuilds each vector, predicts the probabilities in fixed point and checks
// every probability item in order against them.
// ----------------------------------------------------------------------------
module smx_scoreboard #(
   parameter int MAX_LEN = smx_pkg::MAX_LEN_DEF
) (
   input  logic      clock,
   input  logic      reset,
   smx_req_if.sink   req_mon,
   smx_rsp_if.sink   rsp_mon,
   output int        fail_count,
   output int        pending
);

   typedef struct packed {
      logic [smx_pkg::PROB_W-1:0] probability;
      logic                       final_res;
   } prob_item_type;

   prob_item_type                    prob_queue [$];
   logic signed [smx_pkg::LOGIT_W-1:0] vec_store [$];
   int                               vec_max;

   assign pending = prob_queue.size();

   function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = a * b + 128'd2147483648;
      return p[95:32];
   endfunction

   function automatic logic [16:0] exp_neg(input int n);
      logic [63:0] r;
      logic [63:0] b;
      r = 64'h1_0000_0000;
      b = 64'd4278222805;
      if (n >= 8192) return 17'd0;
      for (int j = 0; j < 13; j++) begin
         if (n[j]) r = mul_q32(r, b);
         b = mul_q32(b, b);
      end
      r = (r + 64'd32768) >> 16;
      return r[16:0];
   endfunction

   task automatic predict_vector();
      logic [22:0]   sum;
      logic [63:0]   p;
      logic [16:0]   e;
      prob_item_type it;
      sum = '0;
      foreach (vec_store[i]) sum += exp_neg(vec_max - int'(vec_store[i]));
      foreach (vec_store[i]) begin
         e = exp_neg(vec_max - int'(vec_store[i]));
         p = 0;
         if (sum != 0) begin
            p = ({47'd0, e} * 64'd65536 + {42'd0, sum[22:1]}) / {41'd0, sum};
            if (p > 64'd65535) p = 64'd65535;
         end
         it.probability = p[15:0];
         it.final_res   = (i == vec_store.size() - 1);
         prob_queue.push_back(it);
      end
      vec_store.delete();
      vec_max = -32768;
   endtask

   task automatic report(input string what, input int got, input int want);
      $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      vec_max    = -32768;
   end

   always @(posedge clock) begin
      prob_item_type want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            if (vec_store.size() < MAX_LEN) begin
               vec_store.push_back(req_mon.logit);
               if (int'(req_mon.logit) > vec_max) vec_max = int'(req_mon.logit);
            end
            if (req_mon.last) predict_vector();
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (prob_queue.size() == 0) begin
               report("unexpected item", rsp_mon.probability, -1);
            end else begin
               want = prob_queue.pop_front();
               if (rsp_mon.probability !== want.probability)
                  report("probability", rsp_mon.probability, want.probability);
               if (rsp_mon.final_res !== want.final_res)
                  report("final_res", rsp_mon.final_res, want.final_res);
            end
         end
      end
   end

endmodule

[tb/sv/tb_softmax_vector_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_softmax_vector_unit
// Drives logit vectors of directed and random shape into the softmax vector
// unit with random idling on both channels; the scoreboard checks results.
// ----------------------------------------------------------------------------
module tb_softmax_vector_unit;

   localparam int LIMIT = 1000000;

   logic clock;
   logic reset;
   int   cycles;
   int   fail_count;
   int   pending;
   int   sent;
   bit   quiet;

   smx_req_if req_if ();
   smx_rsp_if rsp_if ();

   softmax_vector_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   smx_scoreboard scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if.sink),
      .rsp_mon    (rsp_if.sink),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver side: random stall bursts
   initial begin
      int n;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 10);
            rsp_if.ready = 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_if.ready = 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   task automatic send_logit(input logic [15:0] x, input logic lst);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.logit = x;
      req_if.last  = lst;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
      req_if.valid = 1'b0;
      sent++;
   endtask

   function automatic logic [15:0] rand_logit(input int spread);
      case ($urandom_range(0, 5))
         0: return 16'($urandom);
         1: return 16'h8000;
         2: return 16'h7FFF;
         default: return 16'($signed($urandom_range(0, 2 * spread)) - spread);
      endcase
   endfunction

   task automatic send_vector(input int len, input int spread);
      for (int i = 0; i < len; i++) send_logit(rand_logit(spread), i == len - 1);
   endtask

   initial begin
      int len;
      cycles = 0;
      sent   = 0;
      quiet  = 1'b0;
      reset  = 1'b1;
      req_if.valid = 1'b0;
      req_if.logit = '0;
      req_if.last  = 1'b0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      send_logit(16'h1234, 1'b1);
      send_logit(16'h7FFF, 1'b0);
      send_logit(16'h8000, 1'b1);
      send_logit(16'h0000, 1'b0);
      send_logit(16'h0000, 1'b0);
      send_logit(16'hFF00, 1'b1);
      send_logit(16'h0000, 1'b0);
      send_logit(16'hE000, 1'b0);
      send_logit(16'hE001, 1'b1);
      send_logit(16'h5555, 1'b0);
      send_logit(16'hAAAA, 1'b1);
      for (int i = 0; i < 70; i++) send_logit(16'($urandom_range(0, 2048)), i == 69);

      while (sent < 220) begin
         if (sent > 190) quiet = 1'b1;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 64) : $urandom_range(1, 8);
         send_vector(len, ($urandom_range(0, 1) != 0) ? 512 : 4096);
      end
      quiet = 1'b1;

      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
